>>> rtl/core/cbm_pkg.sv
// Shared types, field layouts and codes for the cartridge bank mapper.
package cbm_pkg;

  localparam int unsigned MaxRomBanks = 256;

  // Controller variants
  localparam logic [1:0] KIND_ONE   = 2'd0;
  localparam logic [1:0] KIND_TWO   = 2'd1;
  localparam logic [1:0] KIND_THREE = 2'd2;
  localparam logic [1:0] KIND_FIVE  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAPPER_KIND     = 2'd0;
  localparam logic [1:0] CFG_ROM_BANK_COUNT  = 2'd1;
  localparam logic [1:0] CFG_RAM_SIZE_CODE   = 2'd2;
  localparam logic [1:0] CFG_WRAM_UPPER_BANK = 2'd3;

  // Cart RAM size codes
  localparam logic [2:0] RAM_NONE = 3'd0;
  localparam logic [2:0] RAM_2K   = 3'd1;
  localparam logic [2:0] RAM_8K   = 3'd2;
  localparam logic [2:0] RAM_32K  = 3'd3;
  localparam logic [2:0] RAM_128K = 3'd4;
  localparam logic [2:0] RAM_64K  = 3'd5;

  // Result targets
  localparam logic [2:0] TGT_ROM      = 3'd0;
  localparam logic [2:0] TGT_CART_RAM = 3'd1;
  localparam logic [2:0] TGT_WORK_RAM = 3'd2;
  localparam logic [2:0] TGT_CONST_FF = 3'd3;
  localparam logic [2:0] TGT_CONTROL  = 3'd4;
  localparam logic [2:0] TGT_UNMAPPED = 3'd5;

  localparam logic [15:0] ECHO_OFFSET = 16'h2000;
  localparam logic [15:0] ECHO_END    = 16'hFE00;
  localparam logic [8:0]  ROM_LIMIT_CAP = 9'(MaxRomBanks);

  typedef struct packed {
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [21:0] mapped_address;
    logic        write_enable;
    logic [7:0]  data_out;
    logic        bank_error;
    logic        bad_address;
  } out_word_t;

  typedef struct packed {
    logic [1:0] mapper_kind;
    logic [8:0] rom_bank_count;
    logic [2:0] ram_size_code;
    logic       wram_upper_bank;
  } cfg_t;

  typedef struct packed {
    logic       ram_enable;
    logic [7:0] rom_select;
    logic [7:0] rom_bank;
    logic [1:0] ram_bank;
    logic       banking_mode;
  } bank_t;

endpackage

>>> rtl/core/cartridge_bank_mapper_top.sv
// Top level of the cartridge bank mapper: input register, decode, output register.
//
// Usage:
//   in_valid/in_ready/in_data carry one CPU bus word (operation, address,
//   write_data). out_valid/out_ready/out_data carry the translated result
//   (target, mapped_address, write_enable, data_out, bank_error, bad_address).
//   cfg_we/cfg_index/cfg_wdata write the configuration registers;
//   write them only while no word is in flight.
// Path: the input register holds each accepted word, and its decoded result is
//   registered in the output register.
// Throughput: one word per cycle while out_ready is high. The decode and bank
//   update sit in one short logic layer between the input and output registers,
//   and the bank registers update as each word moves into the output register.
// Reset: synchronous active-low rst_n empties both registers and restores
//   the bank state (RAM disabled, ROM select and bank 1, RAM bank 0, mode 0)
//   and the configuration defaults.
// Stall: when out_ready is low with a result waiting, the input register holds
//   its word and in_ready drops only once that register is full too; no word
//   is dropped or repeated.
module cartridge_bank_mapper_top import cbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      s1_advance;
  cfg_t      cfg_q;
  bank_t     bank_q;
  bank_t     bank_nxt;
  out_word_t dec_word;

  // move the held word on whenever the output register is free or draining
  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
  end

  cbm_decode u_decode (
    .word_in  (s1_word_r),
    .cfg      (cfg_q),
    .bank     (bank_q),
    .word_out (dec_word),
    .bank_nxt (bank_nxt)
  );

  // commit bank updates in the same cycle the word leaves the input register
  cbm_bank_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .upd_en    (s1_advance),
    .bank_nxt  (bank_nxt),
    .cfg_q     (cfg_q),
    .bank_q    (bank_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_word_r <= dec_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

`ifndef SYNTHESIS
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_advance |=> s1_valid_r && $stable(s1_word_r))
    else $error("input register lost a stalled word");

  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bank_q.rom_bank != 8'd0)
    else $error("active ROM bank is zero");

  a_bad_is_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.bad_address |-> out_word_r.target == TGT_UNMAPPED)
    else $error("bad address without unmapped target");

  a_err_on_control: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.bank_error |-> out_word_r.target == TGT_CONTROL)
    else $error("bank error outside a control write");

  a_we_on_ram: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.write_enable |->
      (out_word_r.target == TGT_CART_RAM || out_word_r.target == TGT_WORK_RAM))
    else $error("write enable on a non-RAM target");
`endif

endmodule

>>> rtl/core/cbm_bank_regs.sv
// Configuration registers and bank state registers of the mapper.
module cbm_bank_regs import cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  input  logic       upd_en,
  input  bank_t      bank_nxt,
  output cfg_t       cfg_q,
  output bank_t      bank_q
);

  cfg_t  cfg_r;
  bank_t bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapper_kind     <= KIND_ONE;
      cfg_r.rom_bank_count  <= 9'd2;
      cfg_r.ram_size_code   <= RAM_NONE;
      cfg_r.wram_upper_bank <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAPPER_KIND:     cfg_r.mapper_kind     <= cfg_wdata[1:0];
        CFG_ROM_BANK_COUNT:  cfg_r.rom_bank_count  <= cfg_wdata;
        CFG_RAM_SIZE_CODE:   cfg_r.ram_size_code   <= cfg_wdata[2:0];
        CFG_WRAM_UPPER_BANK: cfg_r.wram_upper_bank <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r.ram_enable   <= 1'b0;
      bank_r.rom_select   <= 8'd1;
      bank_r.rom_bank     <= 8'd1;
      bank_r.ram_bank     <= 2'd0;
      bank_r.banking_mode <= 1'b0;
    end else if (upd_en) begin
      bank_r <= bank_nxt;
    end
  end

  assign cfg_q  = cfg_r;
  assign bank_q = bank_r;

endmodule

>>> rtl/core/cbm_decode.sv
// Address decode, bank select rules and address translation for one bus word.
module cbm_decode import cbm_pkg::*; (
  input  in_word_t  word_in,
  input  cfg_t      cfg,
  input  bank_t     bank,
  output out_word_t word_out,
  output bank_t     bank_nxt
);

  logic [15:0] addr;
  logic [7:0]  val;
  logic        wr;
  logic        old_kind;
  logic [7:0]  sel_new;
  logic [7:0]  rom_cand;
  logic [8:0]  rom_limit;
  logic        rom_reject;
  logic        ram_reject;
  logic        ram_fits;
  logic        do_rom;
  logic        do_ram;

  always_comb begin
    wr  = word_in.operation;
    val = word_in.write_data;
    // fold echo RAM down onto work RAM
    if (word_in.address[15:13] == 3'b111 && word_in.address < ECHO_END) begin
      addr = word_in.address - ECHO_OFFSET;
    end else begin
      addr = word_in.address;
    end
    old_kind = (cfg.mapper_kind == KIND_ONE) || (cfg.mapper_kind == KIND_TWO);
  end

  // candidate ROM select for the two select windows; the second may select a RAM bank instead
  always_comb begin
    do_rom  = 1'b0;
    do_ram  = 1'b0;
    sel_new = bank.rom_select;
    if (wr && !addr[15]) begin
      case (addr[14:13])
        2'd1: begin
          do_rom  = 1'b1;
          sel_new = old_kind ? {1'b0, bank.rom_select[6:5], val[4:0]} : val;
        end
        2'd2: begin
          if (bank.banking_mode || !old_kind) begin
            do_ram = 1'b1;
          end else begin
            do_rom  = 1'b1;
            sel_new = {1'b0, val[1:0], bank.rom_select[4:0]};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rom_cand = (sel_new == 8'd0) ? 8'd1 : sel_new;
    if (old_kind && (rom_cand == 8'h20 || rom_cand == 8'h40 || rom_cand == 8'h60)) begin
      rom_cand = rom_cand + 8'd1;
    end
    rom_limit  = (cfg.rom_bank_count > ROM_LIMIT_CAP) ? ROM_LIMIT_CAP : cfg.rom_bank_count;
    rom_reject = {1'b0, rom_cand} >= rom_limit;
    // RAM bank count per size code: 2K and none have no full bank, 8K has one
    unique case (cfg.ram_size_code)
      RAM_8K:                     ram_reject = (val[1:0] != 2'd0);
      RAM_32K, RAM_128K, RAM_64K: ram_reject = 1'b0;
      default:                    ram_reject = 1'b1;
    endcase
    unique case (cfg.ram_size_code)
      RAM_2K:                             ram_fits = (addr[12:11] == 2'd0);
      RAM_8K, RAM_32K, RAM_128K, RAM_64K: ram_fits = 1'b1;
      default:                            ram_fits = 1'b0;
    endcase
  end

  always_comb begin
    bank_nxt = bank;
    word_out = '0;
    word_out.data_out = wr ? val : 8'd0;
    word_out.target   = TGT_UNMAPPED;

    if (wr && !addr[15]) begin
      word_out.target         = TGT_CONTROL;
      word_out.mapped_address = {6'd0, addr};
      case (addr[14:13])
        2'd0: bank_nxt.ram_enable = (cfg.mapper_kind == KIND_TWO) ?
                                    (val != 8'd0) : (val[3:0] == 4'hA);
        2'd3: bank_nxt.banking_mode = val[0];
        default: ;
      endcase
      if (do_rom) begin
        bank_nxt.rom_select  = sel_new;
        word_out.bank_error  = rom_reject;
        if (!rom_reject) begin
          bank_nxt.rom_bank = rom_cand;
        end
      end
      if (do_ram) begin
        word_out.bank_error = ram_reject;
        if (!ram_reject) begin
          bank_nxt.ram_bank = val[1:0];
        end
      end
    end else if (!addr[15]) begin
      word_out.target = TGT_ROM;
      if (!addr[14]) begin
        word_out.mapped_address = {6'd0, addr};
      end else begin
        word_out.mapped_address = {bank.rom_bank, addr[13:0]};
      end
    end else begin
      case (addr[14:12])
        3'b010, 3'b011: begin
          if (bank.ram_enable && ram_fits) begin
            word_out.target         = TGT_CART_RAM;
            word_out.mapped_address = {7'd0, bank.ram_bank, addr[12:0]};
            word_out.write_enable   = wr;
          end else begin
            word_out.target = TGT_CONST_FF;
          end
        end
        3'b100: begin
          word_out.target         = TGT_WORK_RAM;
          word_out.mapped_address = {10'd0, addr[11:0]};
          word_out.write_enable   = wr;
        end
        3'b101: begin
          word_out.target         = TGT_WORK_RAM;
          word_out.mapped_address = {9'd0, cfg.wram_upper_bank, addr[11:0]};
          word_out.write_enable   = wr;
        end
        default: begin
          word_out.bad_address = 1'b1;
        end
      endcase
    end
  end

endmodule

>>> bench/cartridge_bank_mapper_top_tb.sv
// Self-checking bench for the cartridge bank mapper: directed table, then random bus words.
module cartridge_bank_mapper_top_tb;
  import cbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Size codes past the last legal one; both must read as "no cart RAM".
  localparam logic [2:0] RAM_SPARE_A = 3'd6;
  localparam logic [2:0] RAM_SPARE_B = 3'd7;

  localparam int WORDS_PER_PHASE = 108;
  localparam int PHASES          = 12;
  localparam int IDLE_MAX        = 12;
  localparam int SETTLE_CYCLES   = 6;    // two-stage pipe plus margin
  localparam int HOLD_OFF_CYCLES = 60;   // long back-pressure stretch
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PRINT_CAP       = 30;

  // One row of the directed table. When checked is low the predictor
  // supplies the expected word instead of the typed-in one.
  typedef struct packed {
    logic      operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        checked;
    out_word_t   want;
  } bus_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam bus_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Accesses right after reset: fixed ROM, banked ROM (bank 1), holes.
    '{1'b0, 16'h0000, 8'h00, 1'b1, '{TGT_ROM, 22'h000000, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b0, 16'h3FFF, 8'hA5, 1'b1, '{TGT_ROM, 22'h003FFF, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b0, 16'h4000, 8'h00, 1'b1, '{TGT_ROM, 22'h004000, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b0, 16'h7FFF, 8'h00, 1'b1, '{TGT_ROM, 22'h007FFF, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b0, 16'h8000, 8'h00, 1'b1, '{TGT_UNMAPPED, 22'h0, 1'b0, 8'h00, 1'b0, 1'b1}},
    '{1'b1, 16'h9FFF, 8'h5A, 1'b1, '{TGT_UNMAPPED, 22'h0, 1'b0, 8'h5A, 1'b0, 1'b1}},
    // Cart RAM still disabled: constant byte; then work RAM writes.
    '{1'b0, 16'hA000, 8'h00, 1'b1, '{TGT_CONST_FF, 22'h0, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, 16'hC000, 8'hFF, 1'b1, '{TGT_WORK_RAM, 22'h000000, 1'b1, 8'hFF, 1'b0, 1'b0}},
    '{1'b1, 16'hDFFF, 8'h00, 1'b1, '{TGT_WORK_RAM, 22'h001FFF, 1'b1, 8'h00, 1'b0, 1'b0}},
    // Echo window edges.
    '{1'b0, 16'hE000, 8'h00, 1'b0, '0},
    '{1'b1, 16'hFDFF, 8'h3C, 1'b0, '0},
    '{1'b0, 16'hFE00, 8'h00, 1'b1, '{TGT_UNMAPPED, 22'h0, 1'b0, 8'h00, 1'b0, 1'b1}},
    '{1'b0, 16'hFFFF, 8'hFF, 1'b1, '{TGT_UNMAPPED, 22'h0, 1'b0, 8'h00, 1'b0, 1'b1}},
    // Control writes: enable, bank zero, rejected selects, mode flips.
    '{1'b1, 16'h0000, 8'h0A, 1'b1, '{TGT_CONTROL, 22'h000000, 1'b0, 8'h0A, 1'b0, 1'b0}},
    '{1'b1, 16'h2000, 8'h00, 1'b1, '{TGT_CONTROL, 22'h002000, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b1, 16'h3FFF, 8'h1F, 1'b1, '{TGT_CONTROL, 22'h003FFF, 1'b0, 8'h1F, 1'b1, 1'b0}},
    '{1'b1, 16'h4000, 8'h03, 1'b1, '{TGT_CONTROL, 22'h004000, 1'b0, 8'h03, 1'b1, 1'b0}},
    '{1'b1, 16'h6000, 8'h01, 1'b1, '{TGT_CONTROL, 22'h006000, 1'b0, 8'h01, 1'b0, 1'b0}},
    '{1'b1, 16'h5FFF, 8'hFF, 1'b1, '{TGT_CONTROL, 22'h005FFF, 1'b0, 8'hFF, 1'b1, 1'b0}},
    '{1'b1, 16'h7FFF, 8'h00, 1'b1, '{TGT_CONTROL, 22'h007FFF, 1'b0, 8'h00, 1'b0, 1'b0}},
    // RAM enabled but none fitted: write is dropped.
    '{1'b1, 16'hBFFF, 8'h77, 1'b1, '{TGT_CONST_FF, 22'h0, 1'b0, 8'h77, 1'b0, 1'b0}},
    '{1'b1, 16'h1FFF, 8'h00, 1'b1, '{TGT_CONTROL, 22'h001FFF, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{1'b0, 16'h4000, 8'h00, 1'b0, '0},
    '{1'b1, 16'hE123, 8'h11, 1'b0, '0}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;

  cartridge_bank_mapper_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mirror of the mapper: configuration and bank registers.
  cfg_t       mapper_cfg;
  bank_t      bank_regs;
  out_word_t  pending_results[$];

  int error_count;
  int words_sent;
  int results_seen;
  int rejected_selects;
  int cart_ram_hits;
  int cycle_count;
  int send_gap_max;
  int recv_stall_max;
  int hold_off_request;

  // Cart RAM size in bytes for a size code; spare codes mean none.
  function automatic int unsigned ram_capacity(input logic [2:0] code);
    case (code)
      RAM_2K:   return 32'h800;
      RAM_8K:   return 32'h2000;
      RAM_32K:  return 32'h8000;
      RAM_128K: return 32'h20000;
      RAM_64K:  return 32'h10000;
      default:  return 0;
    endcase
  endfunction

  // Apply the zero-to-one rule and, for kinds one and two, the 0x20/0x40/0x60 bump
  // rule, then keep the old bank if the result does not fit the ROM. Returns the reject flag.
  function automatic logic select_rom_bank(input logic [7:0] sel);
    int unsigned bank;
    int unsigned limit;
    bank  = sel;
    limit = mapper_cfg.rom_bank_count;
    if (limit > MaxRomBanks) limit = MaxRomBanks;
    if (bank == 0) bank = 1;
    if (mapper_cfg.mapper_kind inside {KIND_ONE, KIND_TWO} &&
        (bank == 'h20 || bank == 'h40 || bank == 'h60))
      bank++;
    if (bank >= limit) return 1'b1;
    bank_regs.rom_bank = 8'(bank);
    return 1'b0;
  endfunction

  function automatic logic select_ram_bank(input logic [1:0] sel);
    int unsigned banks;
    banks = ram_capacity(mapper_cfg.ram_size_code) / 32'h2000;
    if (sel >= banks) return 1'b1;
    bank_regs.ram_bank = sel;
    return 1'b0;
  endfunction

  // Translate one bus word and advance the bank registers.
  function automatic out_word_t translate_access(input in_word_t w);
    out_word_t   r;
    logic [15:0] a;
    logic [7:0]  v;
    int unsigned off;
    r        = '0;
    r.target = TGT_UNMAPPED;
    a        = w.address;
    v        = w.write_data;
    if (a >= 16'hE000 && a < ECHO_END) a = a - ECHO_OFFSET;
    r.data_out = w.operation ? v : 8'h00;
    if (a < 16'h8000 && w.operation) begin
      r.target         = TGT_CONTROL;
      r.mapped_address = 22'(a);
      case (a[14:13])
        2'd0: begin
          if (mapper_cfg.mapper_kind == KIND_TWO) bank_regs.ram_enable = (v != 8'h00);
          else bank_regs.ram_enable = (v[3:0] == 4'hA);
        end
        2'd1: begin
          if (mapper_cfg.mapper_kind inside {KIND_ONE, KIND_TWO})
            bank_regs.rom_select = {1'b0, bank_regs.rom_select[6:5], v[4:0]};
          else
            bank_regs.rom_select = v;
          r.bank_error = select_rom_bank(bank_regs.rom_select);
        end
        2'd2: begin
          if (bank_regs.banking_mode ||
              mapper_cfg.mapper_kind inside {KIND_THREE, KIND_FIVE}) begin
            r.bank_error = select_ram_bank(v[1:0]);
          end else begin
            bank_regs.rom_select = {1'b0, v[1:0], bank_regs.rom_select[4:0]};
            r.bank_error = select_rom_bank(bank_regs.rom_select);
          end
        end
        default: bank_regs.banking_mode = v[0];
      endcase
    end else if (a < 16'h4000) begin
      r.target         = TGT_ROM;
      r.mapped_address = 22'(a);
    end else if (a < 16'h8000) begin
      r.target         = TGT_ROM;
      r.mapped_address = {bank_regs.rom_bank, a[13:0]};
    end else if (a >= 16'hA000 && a < 16'hC000) begin
      off = a - 16'hA000;
      if (bank_regs.ram_enable && off < ram_capacity(mapper_cfg.ram_size_code)) begin
        r.target         = TGT_CART_RAM;
        r.mapped_address = 22'({bank_regs.ram_bank, a[12:0]});
        r.write_enable   = w.operation;
      end else begin
        r.target = TGT_CONST_FF;
      end
    end else if (a >= 16'hC000 && a < 16'hD000) begin
      r.target         = TGT_WORK_RAM;
      r.mapped_address = 22'(a[11:0]);
      r.write_enable   = w.operation;
    end else if (a >= 16'hD000 && a < 16'hE000) begin
      r.target         = TGT_WORK_RAM;
      r.mapped_address = 22'({mapper_cfg.wram_upper_bank, a[11:0]});
      r.write_enable   = w.operation;
    end else begin
      r.bad_address = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < PRINT_CAP)
      $display("mismatch @%0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Random bus word. Most words are control writes or hits on the mapped
  // regions, so bank switching sequences form often; the rest is noise.
  function automatic in_word_t next_access();
    in_word_t w;
    int       pick;
    pick         = $urandom_range(0, 99);
    w.operation  = 1'($urandom);
    w.address    = 16'($urandom);
    w.write_data = 8'($urandom);
    if (pick < 40) begin
      w.operation = 1'b1;
      w.address   = 16'($urandom_range(0, 16'h7FFF));
      case (w.address[14:13])
        2'd0: if ($urandom_range(0, 1)) w.write_data[3:0] = 4'hA;
        2'd1: begin
          case ($urandom_range(0, 9))
            0: w.write_data = 8'h00;
            1: w.write_data = 8'h20;
            2: w.write_data = 8'h40;
            3: w.write_data = 8'h60;
            4: w.write_data = 8'h1F;
            5: w.write_data = 8'hFF;
            6: w.write_data = 8'h01;
            default: ;
          endcase
        end
        default: ;
      endcase
    end else if (pick < 55) begin
      w.operation = 1'b0;
      w.address   = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick < 75) begin
      w.address = 16'($urandom_range(16'hA000, 16'hBFFF));
    end else if (pick < 90) begin
      w.address = 16'($urandom_range(16'hC000, 16'hFDFF));
    end
    return w;
  endfunction

  // Offer one word after a random gap and record its prediction on accept.
  // Enter and leave on a falling edge.
  task automatic send_word(input in_word_t w, input out_word_t typed, input logic use_typed);
    int gap;
    out_word_t predicted;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = translate_access(w);
    if (predicted.bank_error) rejected_selects++;
    if (predicted.target == TGT_CART_RAM) cart_ram_hits++;
    pending_results.push_back(use_typed ? typed : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every result to drain, then let the pipe empty.
  task automatic settle_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [8:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      CFG_MAPPER_KIND:    mapper_cfg.mapper_kind     = value[1:0];
      CFG_ROM_BANK_COUNT: mapper_cfg.rom_bank_count  = value;
      CFG_RAM_SIZE_CODE:  mapper_cfg.ram_size_code   = value[2:0];
      default:            mapper_cfg.wram_upper_bank = value[0];
    endcase
    @(negedge clk);
  endtask

  function automatic cfg_t phase_setting(input int p);
    cfg_t c;
    case (p)
      0:  c = '{KIND_ONE,   9'd2,   RAM_NONE,    1'b1};
      1:  c = '{KIND_ONE,   9'd256, RAM_32K,     1'b0};
      2:  c = '{KIND_TWO,   9'd2,   RAM_8K,      1'b1};
      3:  c = '{KIND_THREE, 9'd128, RAM_128K,    1'b0};
      4:  c = '{KIND_FIVE,  9'd256, RAM_64K,     1'b1};
      5:  c = '{KIND_ONE,   9'd64,  RAM_2K,      1'b0};
      6:  c = '{KIND_TWO,   9'd256, RAM_SPARE_A, 1'b1};
      7:  c = '{KIND_THREE, 9'd3,   RAM_SPARE_B, 1'b0};
      8:  c = '{KIND_FIVE,  9'd33,  RAM_NONE,    1'b1};
      default: begin
        c.mapper_kind     = 2'($urandom);
        c.rom_bank_count  = 9'($urandom_range(2, MaxRomBanks));
        c.ram_size_code   = 3'($urandom_range(0, 7));
        c.wram_upper_bank = 1'($urandom);
      end
    endcase
    return c;
  endfunction

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result side: stall a random number of cycles per word, honor a long
  // hold-off when one is requested, and check each accepted result against
  // the oldest prediction.
  initial begin : result_side
    int        stall;
    out_word_t want;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_request > 0) begin
        stall            = hold_off_request;
        hold_off_request = 0;
      end else begin
        stall = $urandom_range(0, recv_stall_max);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, target", out_data.target, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.target != want.target)
          report_mismatch("target", out_data.target, want.target);
        if (out_data.mapped_address != want.mapped_address)
          report_mismatch("mapped_address", out_data.mapped_address, want.mapped_address);
        if (out_data.write_enable != want.write_enable)
          report_mismatch("write_enable", out_data.write_enable, want.write_enable);
        if (out_data.data_out != want.data_out)
          report_mismatch("data_out", out_data.data_out, want.data_out);
        if (out_data.bank_error != want.bank_error)
          report_mismatch("bank_error", out_data.bank_error, want.bank_error);
        if (out_data.bad_address != want.bad_address)
          report_mismatch("bad_address", out_data.bad_address, want.bad_address);
      end
      @(negedge clk);
    end
  end

  // Bus side: reset, directed table, then one random phase per setting.
  initial begin : bus_side
    cfg_t plan;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_ready        = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MAPPER_KIND;
    cfg_wdata        = '0;
    error_count      = 0;
    words_sent       = 0;
    results_seen     = 0;
    rejected_selects = 0;
    cart_ram_hits    = 0;
    cycle_count      = 0;
    hold_off_request = 0;
    send_gap_max     = IDLE_MAX;
    recv_stall_max   = IDLE_MAX;

    // Reset values of the mirror match the block after reset.
    mapper_cfg = '{KIND_ONE, 9'd2, RAM_NONE, 1'b1};
    bank_regs  = '{1'b0, 8'd1, 8'd1, 2'd0, 1'b0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the table on the reset configuration.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_word('{DIRECTED[r].operation, DIRECTED[r].address, DIRECTED[r].write_data},
                DIRECTED[r].want, DIRECTED[r].checked);
    end

    for (int p = 0; p < PHASES; p++) begin
      // Reprogram only with the pipe empty.
      settle_idle();
      plan = phase_setting(p);
      program_reg(CFG_MAPPER_KIND,     9'(plan.mapper_kind));
      program_reg(CFG_ROM_BANK_COUNT,  plan.rom_bank_count);
      program_reg(CFG_RAM_SIZE_CODE,   9'(plan.ram_size_code));
      program_reg(CFG_WRAM_UPPER_BANK, 9'(plan.wram_upper_bank));
      cfg_we = 1'b0;

      // Every third phase runs flat out on both sides, apart from the hold-off below.
      send_gap_max   = (p % 3 == 0) ? 0 : IDLE_MAX;
      recv_stall_max = (p % 3 == 0) ? 0 : IDLE_MAX;

      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // Back-pressure the result side while words keep coming, so the
        // pipe fills and in_ready has to drop.
        if (p == 3 && i == 20) hold_off_request = HOLD_OFF_CYCLES;
        send_word(next_access(), '0, 1'b0);
      end
    end

    settle_idle();

    $display("sent %0d bus words over %0d mapper settings, checked %0d results",
             words_sent, PHASES + 1, results_seen);
    $display("rejected bank selects %0d, cart RAM accesses %0d, mismatches %0d",
             rejected_selects, cart_ram_hits, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
